[hdl/sgpg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine grating pixel generator package
// Register codes, sine polynomial coefficients and pipeline tag type.
// ----------------------------------------------------------------------------
package sgpg_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Y       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONTRAST     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_START   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_WIDTH   = 3'd6;

  // Odd Taylor-style coefficients of sin(pi/2 * x), Q30
  localparam logic signed [32:0] CO_A1 = 33'sd1686629713;
  localparam logic signed [32:0] CO_A3 = -33'sd693598671;
  localparam logic signed [32:0] CO_A5 = 33'sd85569306;
  localparam logic signed [32:0] CO_A7 = -33'sd5026997;
  localparam logic [30:0]        CO_A9 = 31'd172271;

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  // Additive coefficient of each Horner step
  function automatic logic signed [32:0] horner_coef(input logic [2:0] step);
    logic signed [32:0] c;
    case (step)
      3'd1:    c = CO_A7;
      3'd2:    c = CO_A5;
      3'd3:    c = CO_A3;
      3'd4:    c = CO_A1;
      default: c = '0;
    endcase
    return c;
  endfunction

  typedef struct packed {
    logic span;
    logic row_end;
    logic frame_end;
  } pix_tag_t;

endpackage

[hdl/sgpg_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sgpg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr_i,
  output logic [WIDTH-1:0]           rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/sine_grating_pixel_generator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine grating pixel generator
// Raster-order DDS grating: phase accumulator, sine table RAM, gray mapping,
// byte-swapped RGB565 output.
// An input transfer reaches result valid through the stage 1, stage 2 and
// output registers. One pixel per cycle, set by the single-add phase update,
// while in_stall_o is low. After reset the sine table is built with one
// shared 31x31 multiplier; in_stall_o stays high meanwhile.
// Reset clears counters and phases and loads register defaults.
// ----------------------------------------------------------------------------
module sine_grating_pixel_generator_top #(
  parameter int unsigned LUT_ENTRIES = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sgpg_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [sgpg_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                frame_start_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [15:0]                         pixel_o,
  output logic                                row_end_o,
  output logic                                frame_end_o
);

  import sgpg_pkg::*;

  localparam int unsigned AW = $clog2(LUT_ENTRIES);
  localparam int unsigned NW = $clog2(LUT_ENTRIES + 1);
  localparam int unsigned RW = AW + 1;
  localparam logic [NW-1:0] LUT_N   = NW'(LUT_ENTRIES);
  localparam logic [RW-1:0] LUT_NR  = RW'(LUT_ENTRIES);
  localparam logic [AW-1:0] LAST_K  = AW'(LUT_ENTRIES - 1);
  localparam logic [31:0]   T_QUO   = 32'((64'd1 << 32) / LUT_ENTRIES);
  localparam logic [RW-1:0] T_REM   = RW'((64'd1 << 32) % LUT_ENTRIES);
  localparam logic signed [48:0] GRAY_BIAS = 49'sh4000_0000_0000;

  localparam logic [2:0] F_LOAD = 3'd0;
  localparam logic [2:0] F_MUL  = 3'd1;
  localparam logic [2:0] F_ADD  = 3'd2;
  localparam logic [2:0] F_NEXT = 3'd3;
  localparam logic [2:0] F_RUN  = 3'd4;

  // Configuration
  logic [31:0] step_x_q, step_y_q;
  logic [15:0] c255_q;
  logic [11:0] row_width_q, frame_height_q, span_start_q, span_width_q;
  logic [8:0]  csat;

  assign csat = (cfg_data_i[8:0] > 9'd256) ? 9'd256 : cfg_data_i[8:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_x_q       <= '0;
      step_y_q       <= '0;
      c255_q         <= 16'd65280;
      row_width_q    <= 12'd320;
      frame_height_q <= 12'd240;
      span_start_q   <= '0;
      span_width_q   <= 12'd320;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_STEP_X:       step_x_q       <= cfg_data_i;
        REG_STEP_Y:       step_y_q       <= cfg_data_i;
        REG_CONTRAST:     c255_q         <= 16'({csat, 8'd0} - {8'd0, csat});
        REG_ROW_WIDTH:    row_width_q    <= cfg_data_i[11:0];
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[11:0];
        REG_SPAN_START:   span_start_q   <= cfg_data_i[11:0];
        REG_SPAN_WIDTH:   span_width_q   <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // Sine table build sequencer
  logic [2:0]         fsm_q, fsm_d;
  logic [2:0]         step_q, step_d;
  logic [AW-1:0]      k_q, k_d;
  logic [31:0]        t_q, t_d;
  logic [RW-1:0]      rem_q, rem_d;
  logic [1:0]         quad_q, quad_d;
  logic [30:0]        x_q, x_d, x2_q, x2_d, bm_q, bm_d;
  logic               bn_q, bn_d, pneg_q, pneg_d;
  logic [61:0]        mprod_q, mprod_d;
  logic signed [32:0] val_q, val_d;
  logic [30:0]        mul_a, r_ext;
  logic [RW-1:0]      rem_sum;
  logic               rem_carry;
  logic signed [32:0] mterm, val_abs;
  logic [31:0]        s_clamp, s_fill;
  logic               ram_we;
  logic               busy;

  assign busy      = (fsm_q != F_RUN);
  assign mul_a     = ((step_q == 3'd0) || (step_q == 3'd5)) ? x_q : x2_q;
  assign r_ext     = {1'b0, t_q[29:0]};
  assign rem_sum   = rem_q + T_REM;
  assign rem_carry = (rem_sum >= LUT_NR);
  assign mterm     = {1'b0, mprod_q[61:30]};
  assign val_abs   = val_q[32] ? -val_q : val_q;
  assign s_clamp   = val_q[32] ? 32'd0 :
                     (val_q > 33'sd1073741824) ? 32'h4000_0000 : val_q[31:0];
  assign s_fill    = quad_q[1] ? (32'd0 - s_clamp) : s_clamp;

  always_comb begin
    fsm_d   = fsm_q;
    step_d  = step_q;
    k_d     = k_q;
    t_d     = t_q;
    rem_d   = rem_q;
    quad_d  = quad_q;
    x_d     = x_q;
    x2_d    = x2_q;
    bm_d    = bm_q;
    bn_d    = bn_q;
    pneg_d  = pneg_q;
    mprod_d = mprod_q;
    val_d   = val_q;
    ram_we  = 1'b0;
    case (fsm_q)
      F_LOAD: begin
        quad_d = t_q[31:30];
        x_d    = t_q[30] ? (Q30_ONE - r_ext) : r_ext;
        bm_d   = t_q[30] ? (Q30_ONE - r_ext) : r_ext;
        bn_d   = 1'b0;
        step_d = 3'd0;
        fsm_d  = F_MUL;
      end
      F_MUL: begin
        mprod_d = {31'd0, mul_a} * {31'd0, bm_q};
        pneg_d  = bn_q;
        fsm_d   = F_ADD;
      end
      F_ADD: begin
        val_d = pneg_q ? (horner_coef(step_q) - mterm) : (horner_coef(step_q) + mterm);
        fsm_d = F_NEXT;
      end
      F_NEXT: begin
        if (step_q == 3'd0) begin
          x2_d   = val_q[30:0];
          bm_d   = CO_A9;
          bn_d   = 1'b0;
          step_d = 3'd1;
          fsm_d  = F_MUL;
        end else if (step_q != 3'd5) begin
          bm_d   = val_abs[30:0];
          bn_d   = val_q[32];
          step_d = step_q + 3'd1;
          fsm_d  = F_MUL;
        end else begin
          ram_we = 1'b1;
          if (k_q == LAST_K) begin
            fsm_d = F_RUN;
          end else begin
            k_d   = k_q + AW'(1);
            rem_d = rem_carry ? (rem_sum - LUT_NR) : rem_sum;
            t_d   = t_q + T_QUO + {31'd0, rem_carry};
            fsm_d = F_LOAD;
          end
        end
      end
      default: fsm_d = F_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q  <= F_LOAD;
      step_q <= '0;
      k_q    <= '0;
      t_q    <= '0;
      rem_q  <= '0;
    end else begin
      fsm_q  <= fsm_d;
      step_q <= step_d;
      k_q    <= k_d;
      t_q    <= t_d;
      rem_q  <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quad_q  <= quad_d;
    x_q     <= x_d;
    x2_q    <= x2_d;
    bm_q    <= bm_d;
    bn_q    <= bn_d;
    pneg_q  <= pneg_d;
    mprod_q <= mprod_d;
    val_q   <= val_d;
  end

  // Pixel pipeline
  logic        adv, accept;
  logic [31:0] phase_q, phase_d, rowph_q, rowph_d;
  logic [11:0] col_q, col_d, row_q, row_d;
  logic [31:0] phase0, rowph0, rowph_n;
  logic [11:0] col0, row0, rw, fh;
  logic        in_span, rend, fend;
  logic [32+NW-1:0] idx_prod;
  logic [31:0] ram_rdata;
  pix_tag_t    tag0, s1_tag_q, s2_tag_q;
  logic        s1_vld_q, s2_vld_q, out_vld_q;
  logic signed [48:0] cs_full, s2_prod_q, gsum;
  logic [8:0]  gv;
  logic [7:0]  gray;
  logic [15:0] c565, pixel_q;
  logic        row_end_q, frame_end_q;

  assign adv        = !out_vld_q || !out_stall_i;
  assign in_stall_o = busy || !adv;
  assign accept     = in_valid_i && !in_stall_o;

  assign phase0 = frame_start_i ? 32'd0 : phase_q;
  assign rowph0 = frame_start_i ? 32'd0 : rowph_q;
  assign col0   = frame_start_i ? 12'd0 : col_q;
  assign row0   = frame_start_i ? 12'd0 : row_q;
  assign rw     = (row_width_q == 12'd0) ? 12'd1 : row_width_q;
  assign fh     = (frame_height_q == 12'd0) ? 12'd1 : frame_height_q;

  assign in_span = (col0 >= span_start_q) && ((col0 - span_start_q) < span_width_q);
  assign rend    = ({1'b0, col0} + 13'd1) >= {1'b0, rw};
  assign fend    = rend && (({1'b0, row0} + 13'd1) >= {1'b0, fh});
  assign rowph_n = fend ? 32'd0 : (rowph0 + step_y_q);
  assign tag0    = '{span: in_span, row_end: rend, frame_end: fend};

  always_comb begin
    phase_d = phase_q;
    rowph_d = rowph_q;
    col_d   = col_q;
    row_d   = row_q;
    if (accept) begin
      if (rend) begin
        col_d   = '0;
        row_d   = fend ? 12'd0 : (row0 + 12'd1);
        rowph_d = rowph_n;
        phase_d = rowph_n;
      end else begin
        col_d   = col0 + 12'd1;
        row_d   = row0;
        rowph_d = rowph0;
        phase_d = in_span ? (phase0 + step_x_q) : phase0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      rowph_q <= '0;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      phase_q <= phase_d;
      rowph_q <= rowph_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

  assign idx_prod = {{NW{1'b0}}, phase0} * LUT_N;

  sgpg_ram #(
    .WIDTH (32),
    .DEPTH (LUT_ENTRIES)
  ) u_sine_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (k_q),
    .wdata_i (s_fill),
    .re_i    (adv),
    .raddr_i (idx_prod[32 +: AW]),
    .rdata_o (ram_rdata)
  );

  assign cs_full = $signed(ram_rdata) * $signed({1'b0, c255_q});
  assign gsum    = GRAY_BIAS + s2_prod_q;
  assign gv      = gsum[47:39];
  assign gray    = gsum[48] ? 8'd0 : ((gv > 9'd255) ? 8'd255 : gv[7:0]);
  assign c565    = {gray[7:3], gray[7:2], gray[7:3]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= accept;
      s2_vld_q  <= s1_vld_q;
      out_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_tag_q    <= tag0;
      s2_tag_q    <= s1_tag_q;
      s2_prod_q   <= cs_full;
      pixel_q     <= s2_tag_q.span ? {c565[7:0], c565[15:8]} : 16'd0;
      row_end_q   <= s2_tag_q.row_end;
      frame_end_q <= s2_tag_q.frame_end;
    end
  end

  assign out_valid_o = out_vld_q;
  assign pixel_o     = pixel_q;
  assign row_end_o   = row_end_q;
  assign frame_end_o = frame_end_q;

endmodule

[hdl/sgpg_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine grating pixel generator port checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module sgpg_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] pixel_o,
  input logic        row_end_o,
  input logic        frame_end_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(pixel_o) && $stable(row_end_o) && $stable(frame_end_o))
    else $error("stalled result changed");

  a_frame_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> row_end_o)
    else $error("frame end without row end");

  // gray pixel: all three swapped RGB565 channels derive from one level
  a_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pixel_o[7:3] == pixel_o[12:8]) && (pixel_o[2:0] == pixel_o[7:5])
                    && (pixel_o[15:14] == pixel_o[4:3]))
    else $error("pixel is not a gray level");

endmodule

bind sine_grating_pixel_generator_top sgpg_chk u_sgpg_chk (.*);
